[sv/dvf_pkg.sv]
// Package for the distinct value filter: field widths, controller states
// and the command and status structs between controller and datapath.
// No dependencies; imported by every module of the block.
package dvf_pkg;

   // Fixed field widths of the request and response words.
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned SLOT_W  = 6;
   localparam int unsigned RSP_W   = 40;

   // Bit positions inside the response word.
   localparam int unsigned RSP_NEW_BIT  = 32;
   localparam int unsigned RSP_SLOT_LO  = 33;
   localparam int unsigned RSP_OVFL_BIT = 39;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HOLD
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // latch the accepted word and start the table scan
      logic scan;       // scan step: compare and issue the next table read
      logic push_now;   // load the output register from the live result
      logic push_held;  // load the output register from the held result
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic conclude;   // scan ends this cycle (match found or table exhausted)
      logic out_free;   // output register can take a word this cycle
   } sts_type;

endpackage

[sv/dvf_controller.sv]
// Controller state machine of the distinct value filter.
// Sequences accept, table scan and result hand-off; depends on dvf_pkg.
module dvf_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  dvf_pkg::sts_type sts,
   output dvf_pkg::cmd_type cmd
);
   import dvf_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.conclude) begin
               if (sts.out_free) begin
                  cmd.push_now = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (sts.out_free) begin
               cmd.push_held = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[sv/dvf_datapath.sv]
// Datapath of the distinct value filter: value table memory, entry count,
// scan counter, comparator and output register. Depends on dvf_pkg.
module dvf_datapath #(
   parameter int unsigned DEPTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [dvf_pkg::VALUE_W-1:0]   req_tdata,
   input  logic                          req_tlast,
   input  dvf_pkg::cmd_type              cmd,
   output dvf_pkg::sts_type              sts,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [dvf_pkg::RSP_W-1:0]     rsp_tdata,
   output logic                          rsp_tlast
);
   import dvf_pkg::*;

   localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned SW = (CW > SLOT_W) ? CW : SLOT_W;

   // Value table; entries below the count are always written before read.
   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   logic [VALUE_W-1:0] value_ff;
   logic               last_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      scan_ff, scan_in;
   logic [IW-1:0]      cmp_idx_ff, cmp_idx_in;
   logic               cmp_vld_ff, cmp_vld_in;

   logic [RSP_W-1:0]   res_ff;
   logic               res_last_ff;
   logic [RSP_W-1:0]   out_data_ff;
   logic               out_last_ff;
   logic               out_vld_ff, out_vld_in;

   logic               hit, full, conclude, miss, wr_en, rd_en, push;
   logic [IW-1:0]      rd_addr;
   logic [CW-1:0]      slot_val;
   logic [SW-1:0]      slot_ext;
   logic [RSP_W-1:0]   res_now;
   logic               out_free;

   // Compare the registered read against the value under search.
   assign hit      = cmp_vld_ff && (rd_data_ff == value_ff);
   assign full     = (count_ff == CW'(DEPTH));
   assign conclude = cmd.scan && (hit || (scan_ff == count_ff));
   assign miss     = conclude && !hit;
   assign wr_en    = miss && !full;

   // Issue one table read a cycle: entry zero on accept, then the scan index.
   assign rd_en   = (cmd.load && (count_ff != '0)) ||
                    (cmd.scan && !conclude && (scan_ff < count_ff));
   assign rd_addr = cmd.load ? '0 : scan_ff[IW-1:0];

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[count_ff[IW-1:0]] <= value_ff;
      end
   end

   // Scan counter and pending-compare tracking.
   always_comb begin
      scan_in    = scan_ff;
      cmp_idx_in = cmp_idx_ff;
      cmp_vld_in = cmp_vld_ff;
      if (cmd.load) begin
         scan_in    = (count_ff != '0) ? CW'(1) : '0;
         cmp_idx_in = '0;
         cmp_vld_in = (count_ff != '0);
      end else if (cmd.scan) begin
         if (conclude) begin
            cmp_vld_in = 1'b0;
         end else if (rd_en) begin
            scan_in    = scan_ff + CW'(1);
            cmp_idx_in = scan_ff[IW-1:0];
            cmp_vld_in = 1'b1;
         end else begin
            cmp_vld_in = 1'b0;
         end
      end
   end

   // Entry count: grows on a stored new value, clears after a last word.
   always_comb begin
      count_in = count_ff;
      if (conclude) begin
         if (last_ff) begin
            count_in = '0;
         end else if (wr_en) begin
            count_in = count_ff + CW'(1);
         end
      end
   end

   // Result word: value, new flag, slot, overflow from the lowest bit up.
   assign slot_val = hit ? CW'(cmp_idx_ff) : count_ff;
   assign slot_ext = SW'(slot_val);
   assign res_now  = {miss && full, slot_ext[SLOT_W-1:0], wr_en, value_ff};

   // Output register, free when empty or drained this cycle.
   assign out_free = !out_vld_ff || rsp_tready;
   assign push     = cmd.push_now || cmd.push_held;

   always_comb begin
      out_vld_in = out_vld_ff;
      if (push) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         cmp_vld_ff <= cmp_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      scan_ff    <= scan_in;
      cmp_idx_ff <= cmp_idx_in;
      if (cmd.load) begin
         value_ff <= req_tdata;
         last_ff  <= req_tlast;
      end
      if (conclude) begin
         res_ff      <= res_now;
         res_last_ff <= last_ff;
      end
      if (cmd.push_now) begin
         out_data_ff <= res_now;
         out_last_ff <= last_ff;
      end else if (cmd.push_held) begin
         out_data_ff <= res_ff;
         out_last_ff <= res_last_ff;
      end
   end

   assign sts.conclude = conclude;
   assign sts.out_free = out_free;
   assign rsp_tvalid   = out_vld_ff;
   assign rsp_tdata    = out_data_ff;
   assign rsp_tlast    = out_last_ff;

   // The entry count never passes the table depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above table depth");

   // The scan index stays within the valid entries while scanning.
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      cmd.scan |-> (scan_ff <= count_ff))
      else $error("scan index past entry count");

   // A word enters the output register only when that register is free.
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      push |-> out_free)
      else $error("output register overwritten");

   // A result is never both new and overflowed.
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[RSP_NEW_BIT] && rsp_tdata[RSP_OVFL_BIT]))
      else $error("new and overflow flags both set");

   // A table write never coincides with a table read.
   a_no_rw: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !rd_en)
      else $error("table read and write in one cycle");

endmodule

[sv/distinct_value_filter_unit.sv]
// Distinct value filter: stream deduplication for a set union.
// Req channel carries value (tdata) and last (tlast); rsp channel returns
// value, new flag, slot and overflow (tdata) with last echoed on tlast.
// One response word is produced for every request word, in order.
// A request is accepted while the unit is idle; the value is compared with
// the stored entries one table read per cycle, and the next request is not
// accepted until that scan has ended and its result has entered the output
// register. The table memory read port sets the scan pace: one entry per cycle.
// A new value is appended to the table; with the table full it is flagged
// as overflow and dropped. A word with last set clears the entry count
// after its own result, so the next union starts empty.
// The response sits in an output register; the unit takes the next request
// while it waits. If the receiver stalls, a second finished result is held
// and the unit stops accepting until the output register drains.
// Reset (synchronous, active high) empties the table count and the output;
// no clearing pass is needed, the table contents stay undefined.
// Depends on dvf_pkg, dvf_controller and dvf_datapath.
module distinct_value_filter_unit #(
   parameter int unsigned DEPTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   // req_tdata: value [31:0]
   input  logic [dvf_pkg::VALUE_W-1:0] req_tdata,
   input  logic                        req_tlast,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // rsp_tdata: value_out [31:0], is_new [32], slot [38:33], overflow [39]
   output logic [dvf_pkg::RSP_W-1:0]   rsp_tdata,
   output logic                        rsp_tlast,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready
);
   import dvf_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencer.
   dvf_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Table, comparator and output register.
   dvf_datapath #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[test/distinct_value_filter_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the distinct value filter unit: directed rows,
// a table-fill burst and random unions, checked against typed expectations or a table predictor.
// Depends on dvf_pkg and distinct_value_filter_unit.
module distinct_value_filter_unit_tb;
   import dvf_pkg::*;

   localparam int unsigned TABLE_DEPTH     = 32;
   localparam int unsigned STALL_LIMIT     = 4000;
   localparam int unsigned SETTLE_CYCLES   = 2 * (TABLE_DEPTH + 1) + 8;
   localparam int unsigned LONG_HOLD       = 250;
   localparam int unsigned ITEMS_PER_PHASE = 180;
   localparam int unsigned PHASE_COUNT     = 4;
   localparam int unsigned DIRECTED_COUNT  = 14;

   // One result word as the unit reports it.
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               is_new;
      logic [SLOT_W-1:0]  slot;
      logic               overflow;
      logic               last;
   } filter_result_type;

   // One directed row; the expected flags count only where typed is set.
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               last;
      logic               typed;
      logic               is_new;
      logic [SLOT_W-1:0]  slot;
      logic               overflow;
   } directed_row_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic [VALUE_W-1:0]   req_tdata  = '0;
   logic                 req_tlast  = 1'b0;
   logic                 req_tvalid = 1'b0;
   wire                  req_tready;
   wire  [RSP_W-1:0]     rsp_tdata;
   wire                  rsp_tlast;
   wire                  rsp_tvalid;
   logic                 rsp_tready = 1'b0;

   // Predictor state: the distinct values of the current union.
   logic [VALUE_W-1:0]   seen_values [TABLE_DEPTH];
   int unsigned          seen_count = 0;

   filter_result_type    expected_results [$];
   filter_result_type    oldest_expected;
   int unsigned          error_count    = 0;
   int unsigned          idle_cycles    = 0;
   int unsigned          send_idle_pct  = 0;
   int unsigned          recv_stall_pct = 0;
   int unsigned          hold_left      = 0;
   bit                   hold_request   = 1'b0;
   int unsigned          items_sent     = 0;

   int unsigned phase_send_idle  [PHASE_COUNT] = '{0, 78, 0, 15};
   int unsigned phase_recv_stall [PHASE_COUNT] = '{0, 0, 78, 15};

   // Extremes, repeats, last-flag clearing and stale entries past the count.
   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      '{32'h0000_0000, 1'b0, 1'b1, 1'b1, 6'd0, 1'b0},
      '{32'h0000_0000, 1'b0, 1'b1, 1'b0, 6'd0, 1'b0},
      '{32'h7FFF_FFFF, 1'b0, 1'b1, 1'b1, 6'd1, 1'b0},
      '{32'h8000_0000, 1'b0, 1'b1, 1'b1, 6'd2, 1'b0},
      '{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 6'd3, 1'b0},
      '{32'h0000_0001, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0},
      '{32'h8000_0000, 1'b0, 1'b1, 1'b0, 6'd2, 1'b0},
      '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 6'd3, 1'b0},
      '{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 6'd0, 1'b0},
      '{32'h0000_0000, 1'b1, 1'b1, 1'b1, 6'd1, 1'b0},
      '{32'h5555_5555, 1'b1, 1'b1, 1'b1, 6'd0, 1'b0},
      '{32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0},
      '{32'h8000_0000, 1'b0, 1'b1, 1'b1, 6'd1, 1'b0},
      '{32'h8000_0000, 1'b1, 1'b1, 1'b0, 6'd1, 1'b0}
   };

   distinct_value_filter_unit #(
      .DEPTH(TABLE_DEPTH)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready)
   );

   always #1 clock = ~clock;

   // Looks the value up among the valid entries, appends it if absent and the
   // table has room, and clears the count after a word that ends the union.
   function automatic filter_result_type predict_union_entry(
      input logic [VALUE_W-1:0] value,
      input logic               last
   );
      filter_result_type result;
      int unsigned       pos;
      int unsigned       match;
      bit                found;
      result.value    = value;
      result.last     = last;
      result.is_new   = 1'b0;
      result.overflow = 1'b0;
      found = 1'b0;
      match = 0;
      for (pos = 0; pos < seen_count; pos++) begin
         if (!found && seen_values[pos] == value) begin
            found = 1'b1;
            match = pos;
         end
      end
      if (found) begin
         result.slot = SLOT_W'(match);
      end else if (seen_count < TABLE_DEPTH) begin
         seen_values[seen_count] = value;
         result.is_new = 1'b1;
         result.slot   = SLOT_W'(seen_count);
         seen_count++;
      end else begin
         // Table full: the value is reported at slot DEPTH and dropped.
         result.overflow = 1'b1;
         result.slot     = SLOT_W'(seen_count);
      end
      if (last) begin
         seen_count = 0;
      end
      return result;
   endfunction

   function automatic filter_result_type make_result(
      input logic [VALUE_W-1:0] value,
      input logic               is_new,
      input int unsigned        slot,
      input logic               overflow,
      input logic               last
   );
      filter_result_type result;
      result.value    = value;
      result.is_new   = is_new;
      result.slot     = SLOT_W'(slot);
      result.overflow = overflow;
      result.last     = last;
      return result;
   endfunction

   // Distinct values for the table-fill burst; the low byte is the index.
   function automatic logic [VALUE_W-1:0] fill_entry(input int unsigned index);
      return 32'h8000_0000 ^ (index * 32'h0101_0101);
   endfunction

   // Offers one word after a random idle gap and records what it must give.
   task automatic offer_word(
      input logic [VALUE_W-1:0] value,
      input logic               last,
      input bit                 typed,
      input filter_result_type  typed_result
   );
      filter_result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      predicted = predict_union_entry(value, last);
      expected_results.push_back(typed ? typed_result : predicted);
   endtask

   // Holds the sender back until every outstanding word has come out.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // One union: values drawn mostly from a small pool so that repeats are
   // common; long unions reach the full table. A few words carry a stray
   // last flag, and some unions run on into the next one without a last.
   task automatic send_union();
      logic [VALUE_W-1:0] pool [48];
      int unsigned        length;
      int unsigned        pool_size;
      int unsigned        i;
      bit                 unterminated;
      logic [VALUE_W-1:0] value;
      logic               last;
      length = ($urandom_range(99) < 25) ? $urandom_range(30, 44) : $urandom_range(1, 16);
      pool_size = (length >= 30) ? length : $urandom_range(1, length + 3);
      unterminated = ($urandom_range(99) < 10);
      for (i = 0; i < pool_size; i++) begin
         case ($urandom_range(11))
            0:       pool[i] = 32'h8000_0000;
            1:       pool[i] = 32'h7FFF_FFFF;
            2:       pool[i] = 32'h0000_0000;
            3:       pool[i] = 32'hFFFF_FFFF;
            default: pool[i] = $urandom();
         endcase
      end
      for (i = 0; i < length; i++) begin
         value = ($urandom_range(99) < 85) ? pool[$urandom_range(pool_size - 1)] : $urandom();
         last  = ((i == length - 1) && !unterminated) || ($urandom_range(99) < 2);
         offer_word(value, last, 1'b0, '0);
      end
      items_sent += length;
   endtask

   // Stimulus: reset, directed rows, table-fill burst, then random phases.
   initial begin
      int unsigned      i;
      int unsigned      phase;
      directed_row_type row;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < DIRECTED_COUNT; i++) begin
         row = directed_rows[i];
         offer_word(row.value, row.last, row.typed,
                    make_result(row.value, row.is_new, row.slot, row.overflow, row.last));
      end

      // Fill the table, overflow it twice, hit the last entry and restart.
      recv_stall_pct = 30;
      for (i = 0; i < TABLE_DEPTH; i++) begin
         offer_word(fill_entry(i), 1'b0, 1'b1, make_result(fill_entry(i), 1'b1, i, 1'b0, 1'b0));
      end
      offer_word(32'h1234_5678, 1'b0, 1'b1,
                 make_result(32'h1234_5678, 1'b0, TABLE_DEPTH, 1'b1, 1'b0));
      offer_word(32'h1234_5678, 1'b0, 1'b1,
                 make_result(32'h1234_5678, 1'b0, TABLE_DEPTH, 1'b1, 1'b0));
      offer_word(fill_entry(TABLE_DEPTH - 1), 1'b1, 1'b1,
                 make_result(fill_entry(TABLE_DEPTH - 1), 1'b0, TABLE_DEPTH - 1, 1'b0, 1'b1));
      offer_word(fill_entry(5), 1'b1, 1'b1, make_result(fill_entry(5), 1'b1, 0, 1'b0, 1'b1));
      wait_for_results();

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         send_idle_pct  = phase_send_idle[phase];
         recv_stall_pct = phase_recv_stall[phase];
         // The first phase opens with a long receiver hold-off under full load.
         if (phase == 0) begin
            hold_request = 1'b1;
         end
         items_sent = 0;
         while (items_sent < ITEMS_PER_PHASE) begin
            send_union();
            if ($urandom_range(99) < 5) begin
               wait_for_results();
            end
         end
         wait_for_results();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("[distinct_value_filter_unit] OK");
      end else begin
         $display("[distinct_value_filter_unit] ERROR");
      end
      $finish;
   end

   // Receiver: random stalls, plus a long hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic check_field(
      input string              field,
      input logic [VALUE_W-1:0] expected,
      input logic [VALUE_W-1:0] actual
   );
      if (actual !== expected) begin
         $error("%s: expected %h, actual %h", field, expected, actual);
         error_count++;
      end
   endtask

   // Each result word is compared with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("result word with none expected: tdata %h, tlast %b", rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            oldest_expected = expected_results.pop_front();
            check_field("value_out", oldest_expected.value, rsp_tdata[VALUE_W-1:0]);
            check_field("is_new", oldest_expected.is_new, rsp_tdata[RSP_NEW_BIT]);
            check_field("slot", oldest_expected.slot, rsp_tdata[RSP_SLOT_LO +: SLOT_W]);
            check_field("overflow", oldest_expected.overflow, rsp_tdata[RSP_OVFL_BIT]);
            check_field("last_out", oldest_expected.last, rsp_tlast);
         end
      end
   end

   // Watchdog: ends the run after too many cycles without any handshake.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("[distinct_value_filter_unit] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
